FILE: rtl/grd_pkg.sv
package grd_pkg;

  // input command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  // generator
  localparam logic [31:0] SEED_RESET = 32'h51ed270b;
  localparam logic [31:0] ZERO_FIX   = 32'h9e3779b9;

  // glyphs and colors
  localparam logic [6:0] GLYPH_BASE   = 7'd33;
  localparam logic [7:0] GLYPH_SPAN   = 8'd94;
  localparam logic [7:0] HEAD_RB      = 8'd205;
  localparam logic [7:0] HEAD_G       = 8'd255;
  localparam logic [7:0] GREEN_STEP   = 8'd14;
  localparam logic [7:0] GREEN_FLOOR  = 8'd40;
  localparam logic [2:0] FLICKER_MASK = 3'd7;

  // modulo unit: 32-bit dividend, 8 dividend bits per cycle
  localparam int MOD_CHUNK = 8;
  localparam int MOD_STEPS = 32 / MOD_CHUNK;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [7:0]  den;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] rem;
  } mod_rsp_t;

  // one xorshift32 step, zero replaced by a fixed constant
  function automatic logic [31:0] grd_xs(input logic [31:0] x);
    logic [31:0] v;
    v = x ^ (x << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return (v == 32'd0) ? ZERO_FIX : v;
  endfunction

endpackage

FILE: rtl/glyph_rain_display_engine.sv
// channel | direction | handshake          | word
// in_     | input     | in_valid/in_stall  | cmd, row, column
// out_    | output    | out_valid/out_stall| glyph, lit, red, green, blue
// apb     | input     | psel/penable/pready| seed at byte address 0
//
// A cell read takes one word per cycle while the output does not stall: memory read,
// then color and output register. A tick walks the columns through the column memory;
// a column that moves costs more than one that waits, each modulo draw going through
// the byte-wise modulo unit. Reset and reinit fill the column and glyph memories.
// No word is taken during a tick or fill, nor while out_stall holds a finished read.
module glyph_rain_display_engine
  import grd_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 64,
  parameter int TAIL = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [4:0]  in_row,
  input  logic [5:0]  in_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_glyph,
  output logic        out_lit,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int HRW   = $clog2(2 * ROWS + TAIL + 2) + 1;
  localparam int DW    = HRW + 2;
  localparam int GM_DEPTH = ROWS << CW;

  localparam logic [7:0]     DEN_START = 8'(2 * ROWS);
  localparam logic [7:0]     DEN_ROWS  = 8'(ROWS);
  localparam logic [CW-1:0]  COL_LAST  = CW'(COLS - 1);
  localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
  localparam logic signed [HRW-1:0] ROWS_S = HRW'(ROWS);
  localparam logic signed [HRW-1:0] RT_S   = HRW'(ROWS + TAIL);

  typedef struct packed {
    logic signed [HRW-1:0] head;
    logic [2:0]            period;
    logic [1:0]            tick;
  } col_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_IH_DRAW, ST_IH_WAIT, ST_IP_DRAW, ST_FILL_DRAW, ST_FILL_WAIT,
    ST_T_RD, ST_T_EVAL, ST_T_HG_WAIT, ST_T_CHK, ST_T_RH_WAIT, ST_T_RP_DRAW,
    ST_T_FL_DRAW, ST_T_FR_WAIT, ST_T_FG_WAIT
  } state_t;

  // configuration
  logic [31:0] seed_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      seed_r <= pwdata;
    end
  end

  // memories and their ports
  logic [6:0]       gm_mem [GM_DEPTH];
  col_ent_t         cm_mem [COLS];
  logic [6:0]       gm_q_r;
  col_ent_t         cm_q_r;
  logic             gm_we_r;
  logic [RW+CW-1:0] gm_waddr_r;
  logic [6:0]       gm_wdata_r;
  logic             cm_we_r;
  logic [CW-1:0]    cm_waddr_r;
  col_ent_t         cm_wdata_r;
  logic             cm_re;
  logic [CW-1:0]    cm_raddr;

  // handshake and read pipeline
  state_t     state_r;
  logic       in_acc;
  logic       rd_acc;
  logic       rd_v_r;
  logic [4:0] rd_row_r;
  logic       rd_oor_r;
  logic       adv1;
  logic       out_valid_r;
  logic [CW-1:0] col_r;

  assign adv1     = rd_v_r && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != ST_IDLE) || gm_we_r || cm_we_r || (rd_v_r && !adv1);
  assign in_acc   = in_valid && !in_stall;
  assign rd_acc   = in_acc && (in_cmd == CMD_READ);

  assign cm_re    = rd_acc || (state_r == ST_T_RD);
  assign cm_raddr = rd_acc ? CW'(in_column) : col_r;

  always_ff @(posedge clk) begin
    if (gm_we_r) begin
      gm_mem[gm_waddr_r] <= gm_wdata_r;
    end
    if (rd_acc) begin
      gm_q_r <= gm_mem[{RW'(in_row), CW'(in_column)}];
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we_r) begin
      cm_mem[cm_waddr_r] <= cm_wdata_r;
    end
    if (cm_re) begin
      cm_q_r <= cm_mem[cm_raddr];
    end
  end

  // modulo unit
  mod_req_t mod_req_r;
  mod_rsp_t mod_rsp;

  grd_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req_r),
    .rsp   (mod_rsp)
  );

  // sequencer for tick and reinit
  logic [31:0]           rnd_r;
  logic [31:0]           rnd_nxt;
  logic [RW-1:0]         row_r;
  logic [RW-1:0]         fl_row_r;
  logic signed [HRW-1:0] head_w_r;
  logic [2:0]            per_w_r;
  logic signed [HRW-1:0] head_inc;
  logic [2:0]            tc;
  logic                  col_last;
  logic [6:0]            glyph_new;

  assign rnd_nxt   = grd_xs(rnd_r);
  assign head_inc  = cm_q_r.head + HRW'(1);
  assign tc        = {1'b0, cm_q_r.tick} + 3'd1;
  assign col_last  = (col_r == COL_LAST);
  assign glyph_new = GLYPH_BASE + mod_rsp.rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_SEED;
      mod_req_r.start <= 1'b0;
      gm_we_r         <= 1'b0;
      cm_we_r         <= 1'b0;
    end else begin
      mod_req_r.start <= 1'b0;
      gm_we_r         <= 1'b0;
      cm_we_r         <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_cmd)
              CMD_TICK: begin
                col_r   <= '0;
                state_r <= ST_T_RD;
              end
              CMD_INIT: state_r <= ST_SEED;
              default: ;
            endcase
          end
        end

        // reinit: per column a start row and a period
        ST_SEED: begin
          rnd_r   <= seed_r;
          col_r   <= '0;
          row_r   <= '0;
          state_r <= ST_IH_DRAW;
        end
        ST_IH_DRAW: begin
          rnd_r     <= rnd_nxt;
          mod_req_r <= '{start: 1'b1, num: rnd_nxt, den: DEN_START};
          state_r   <= ST_IH_WAIT;
        end
        ST_IH_WAIT: begin
          if (mod_rsp.done) begin
            head_w_r <= HRW'(0) - HRW'(mod_rsp.rem);
            state_r  <= ST_IP_DRAW;
          end
        end
        ST_IP_DRAW: begin
          rnd_r      <= rnd_nxt;
          cm_we_r    <= 1'b1;
          cm_waddr_r <= col_r;
          cm_wdata_r <= '{head: head_w_r, period: {1'b0, rnd_nxt[1:0]} + 3'd1, tick: 2'd0};
          if (col_last) begin
            col_r   <= '0;
            state_r <= ST_FILL_DRAW;
          end else begin
            col_r   <= col_r + 1'b1;
            state_r <= ST_IH_DRAW;
          end
        end

        // reinit: grid fill, row by row
        ST_FILL_DRAW: begin
          rnd_r     <= rnd_nxt;
          mod_req_r <= '{start: 1'b1, num: rnd_nxt, den: GLYPH_SPAN};
          state_r   <= ST_FILL_WAIT;
        end
        ST_FILL_WAIT: begin
          if (mod_rsp.done) begin
            gm_we_r    <= 1'b1;
            gm_waddr_r <= {row_r, col_r};
            gm_wdata_r <= glyph_new;
            state_r    <= ST_FILL_DRAW;
            if (col_last) begin
              col_r <= '0;
              if (row_r == ROW_LAST) begin
                state_r <= ST_IDLE;
              end else begin
                row_r <= row_r + 1'b1;
              end
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end

        // tick: read column entry, then update
        ST_T_RD: state_r <= ST_T_EVAL;
        ST_T_EVAL: begin
          if (tc < cm_q_r.period) begin
            cm_we_r    <= 1'b1;
            cm_waddr_r <= col_r;
            cm_wdata_r <= '{head: cm_q_r.head, period: cm_q_r.period, tick: tc[1:0]};
            if (col_last) begin
              state_r <= ST_IDLE;
            end else begin
              col_r   <= col_r + 1'b1;
              state_r <= ST_T_RD;
            end
          end else begin
            head_w_r <= head_inc;
            per_w_r  <= cm_q_r.period;
            if (!head_inc[HRW-1] && head_inc < ROWS_S) begin
              rnd_r     <= rnd_nxt;
              mod_req_r <= '{start: 1'b1, num: rnd_nxt, den: GLYPH_SPAN};
              state_r   <= ST_T_HG_WAIT;
            end else begin
              state_r <= ST_T_CHK;
            end
          end
        end
        ST_T_HG_WAIT: begin
          if (mod_rsp.done) begin
            gm_we_r    <= 1'b1;
            gm_waddr_r <= {head_w_r[RW-1:0], col_r};
            gm_wdata_r <= glyph_new;
            state_r    <= ST_T_CHK;
          end
        end
        // trail gone below the grid: restart above the top
        ST_T_CHK: begin
          if (head_w_r > RT_S) begin
            rnd_r     <= rnd_nxt;
            mod_req_r <= '{start: 1'b1, num: rnd_nxt, den: DEN_ROWS};
            state_r   <= ST_T_RH_WAIT;
          end else begin
            state_r <= ST_T_FL_DRAW;
          end
        end
        ST_T_RH_WAIT: begin
          if (mod_rsp.done) begin
            head_w_r <= HRW'(0) - HRW'(mod_rsp.rem);
            state_r  <= ST_T_RP_DRAW;
          end
        end
        ST_T_RP_DRAW: begin
          rnd_r   <= rnd_nxt;
          per_w_r <= {1'b0, rnd_nxt[1:0]} + 3'd1;
          state_r <= ST_T_FL_DRAW;
        end
        // flicker: one draw in eight rewrites a random cell
        ST_T_FL_DRAW: begin
          if ((rnd_nxt[2:0] & FLICKER_MASK) == 3'd0) begin
            state_r <= ST_T_FR_WAIT;
            mod_req_r <= '{start: 1'b1, num: grd_xs(rnd_nxt), den: DEN_ROWS};
            rnd_r     <= grd_xs(rnd_nxt);
          end else begin
            rnd_r      <= rnd_nxt;
            cm_we_r    <= 1'b1;
            cm_waddr_r <= col_r;
            cm_wdata_r <= '{head: head_w_r, period: per_w_r, tick: 2'd0};
            if (col_last) begin
              state_r <= ST_IDLE;
            end else begin
              col_r   <= col_r + 1'b1;
              state_r <= ST_T_RD;
            end
          end
        end
        ST_T_FR_WAIT: begin
          if (mod_rsp.done) begin
            fl_row_r  <= mod_rsp.rem[RW-1:0];
            rnd_r     <= rnd_nxt;
            mod_req_r <= '{start: 1'b1, num: rnd_nxt, den: GLYPH_SPAN};
            state_r   <= ST_T_FG_WAIT;
          end
        end
        ST_T_FG_WAIT: begin
          if (mod_rsp.done) begin
            gm_we_r    <= 1'b1;
            gm_waddr_r <= {fl_row_r, col_r};
            gm_wdata_r <= glyph_new;
            cm_we_r    <= 1'b1;
            cm_waddr_r <= col_r;
            cm_wdata_r <= '{head: head_w_r, period: per_w_r, tick: 2'd0};
            if (col_last) begin
              state_r <= ST_IDLE;
            end else begin
              col_r   <= col_r + 1'b1;
              state_r <= ST_T_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // read: stage one holds the request while the memories answer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      if (rd_acc) begin
        rd_v_r <= 1'b1;
      end else if (adv1) begin
        rd_v_r <= 1'b0;
      end
    end
    if (rd_acc) begin
      rd_row_r <= in_row;
      rd_oor_r <= (32'(in_row) >= ROWS) || (32'(in_column) >= COLS);
    end
  end

  // color from the distance to the head
  logic [DW-1:0] head_gap;
  logic [7:0]    prod;
  logic [7:0]    green_tail;
  logic [6:0]    glyph_c;
  logic          lit_c;
  logic [7:0]    red_c;
  logic [7:0]    green_c;
  logic [7:0]    blue_c;

  assign head_gap   = DW'(cm_q_r.head) - DW'(rd_row_r);
  assign prod       = {4'd0, head_gap[3:0]} * GREEN_STEP;
  assign green_tail = (HEAD_G - prod < GREEN_FLOOR) ? GREEN_FLOOR : HEAD_G - prod;

  always_comb begin
    glyph_c = 7'd0;
    lit_c   = 1'b0;
    red_c   = 8'd0;
    green_c = 8'd0;
    blue_c  = 8'd0;
    if (!rd_oor_r) begin
      glyph_c = gm_q_r;
      if (head_gap == '0) begin
        lit_c   = 1'b1;
        red_c   = HEAD_RB;
        green_c = HEAD_G;
        blue_c  = HEAD_RB;
      end else if (!head_gap[DW-1] && head_gap < DW'(TAIL)) begin
        lit_c   = 1'b1;
        green_c = green_tail;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv1) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (adv1) begin
      out_glyph <= glyph_c;
      out_lit   <= lit_c;
      out_red   <= red_c;
      out_green <= green_c;
      out_blue  <= blue_c;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == ST_IH_WAIT || state_r == ST_FILL_WAIT ||
                      state_r == ST_T_HG_WAIT || state_r == ST_T_RH_WAIT ||
                      state_r == ST_T_FR_WAIT || state_r == ST_T_FG_WAIT))
    else $error("modulo result arrived outside a wait state");

  a_write_blocks_read: assert property (@(posedge clk) disable iff (!rst_n)
    (gm_we_r || cm_we_r) |-> in_stall)
    else $error("word taken while a memory write is pending");

  a_held_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_v_r && out_valid_r && out_stall) |=> ($stable(gm_q_r) && $stable(cm_q_r)))
    else $error("read data lost while output stalled");

endmodule

FILE: rtl/grd_mod.sv
// Remainder of a 32-bit word by a small divisor (1..128), one byte per cycle.
module grd_mod
  import grd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CW = $clog2(MOD_STEPS);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   num_r;
  logic [7:0]    den_r;
  logic [6:0]    rem_r;
  logic [6:0]    rem_nxt;

  // restoring steps over the top byte of the shifting dividend
  always_comb begin
    logic [7:0] t;
    t = 8'd0;
    rem_nxt = rem_r;
    for (int i = MOD_CHUNK - 1; i >= 0; i--) begin
      t = {rem_nxt, num_r[32 - MOD_CHUNK + i]};
      if (t >= den_r) begin
        t = t - den_r;
      end
      rem_nxt = t[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= 7'd0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= num_r << MOD_CHUNK;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: tb/glyph_rain_display_engine_test.sv
`timescale 1ns / 100ps

module glyph_rain_display_engine_test;
  import grd_pkg::*;

  localparam int ROWS = 32;
  localparam int COLS = 64;
  localparam int TAIL = 16;

  // cmd code the block does not decode
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [2:0] SEED_ADDR = 3'd0;

  // one full column and glyph fill plus margin
  localparam int FILL_CYCLES = 2 + 8 * COLS + 7 * ROWS * COLS + 300;
  localparam int RANDOM_PHASES = 4;
  localparam int WORDS_PER_PHASE = 500;

  typedef struct packed {
    logic [6:0] glyph;
    logic       lit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cell_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_TICK;
  logic [4:0]  in_row = '0;
  logic [5:0]  in_column = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_glyph;
  logic        out_lit;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the rain state
  logic [31:0] seed_value;
  logic [31:0] rng_state;
  logic [6:0]  glyph_at [ROWS][COLS];
  int          head_at [COLS];
  int          period_of [COLS];
  int          ticks_of [COLS];

  cell_view_t  pending_reads [$];

  int error_count = 0;
  int reads_checked = 0;
  int lit_seen = 0;
  int heads_seen = 0;
  int ticks_sent = 0;
  int reinits_sent = 0;
  int ignored_sent = 0;
  int seeds_used = 0;

  // idling controls
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int stall_left = 0;

  glyph_rain_display_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_row(in_row), .in_column(in_column),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_glyph(out_glyph), .out_lit(out_lit),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------
  // rain predictor

  // xorshift32, zero replaced by the fixed constant
  function automatic logic [31:0] next_rand();
    logic [31:0] v;
    v = rng_state ^ (rng_state << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    rng_state = (v == 32'd0) ? ZERO_FIX : v;
    return rng_state;
  endfunction

  function automatic logic [6:0] fresh_glyph();
    return GLYPH_BASE + 7'(next_rand() % GLYPH_SPAN);
  endfunction

  function automatic void reseed_rain();
    rng_state = seed_value;
    for (int c = 0; c < COLS; c++) begin
      head_at[c] = -int'(next_rand() % (2 * ROWS));
      period_of[c] = 1 + int'(next_rand() % 4);
      ticks_of[c] = 0;
    end
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        glyph_at[r][c] = fresh_glyph();
  endfunction

  function automatic void advance_rain();
    int rr;
    for (int c = 0; c < COLS; c++) begin
      ticks_of[c]++;
      if (ticks_of[c] < period_of[c]) continue;
      ticks_of[c] = 0;
      head_at[c]++;
      if (head_at[c] >= 0 && head_at[c] < ROWS)
        glyph_at[head_at[c]][c] = fresh_glyph();
      // whole trail gone: restart above the top with a new speed
      if (head_at[c] - TAIL > ROWS) begin
        head_at[c] = -int'(next_rand() % ROWS);
        period_of[c] = 1 + int'(next_rand() % 4);
      end
      // occasional flicker somewhere in the column
      if ((next_rand() & FLICKER_MASK) == 0) begin
        rr = int'(next_rand() % ROWS);
        glyph_at[rr][c] = fresh_glyph();
      end
    end
  endfunction

  function automatic cell_view_t look_cell(int r, int c);
    cell_view_t v;
    int d;
    int g;
    v = '0;
    if (r >= ROWS || c >= COLS) return v;
    d = head_at[c] - r;
    v.glyph = glyph_at[r][c];
    if (d == 0) begin
      v.lit = 1'b1;
      v.red = HEAD_RB;
      v.green = HEAD_G;
      v.blue = HEAD_RB;
    end else if (d > 0 && d < TAIL) begin
      g = int'(HEAD_G) - int'(GREEN_STEP) * d;
      if (g < int'(GREEN_FLOOR)) g = int'(GREEN_FLOOR);
      v.lit = 1'b1;
      v.green = 8'(g);
    end
    return v;
  endfunction

  function automatic void apply_word(logic [1:0] cmd, logic [4:0] row, logic [5:0] column);
    cell_view_t v;
    case (cmd)
      CMD_TICK: begin
        advance_rain();
        ticks_sent++;
      end
      CMD_INIT: begin
        reseed_rain();
        reinits_sent++;
      end
      CMD_READ: begin
        v = look_cell(int'(row), int'(column));
        pending_reads.push_back(v);
        if (v.lit) lit_seen++;
        if (v.red != 0) heads_seen++;
      end
      default: ignored_sent++;
    endcase
  endfunction

  // ---------------------------------------------------------------
  // result checker

  always @(posedge clk) begin
    cell_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read word glyph=%0d lit=%0d rgb=%0d,%0d,%0d",
                 $time, out_glyph, out_lit, out_red, out_green, out_blue);
        error_count++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (out_glyph !== want.glyph) begin
          $display("%0t: glyph expected %0d actual %0d", $time, want.glyph, out_glyph);
          error_count++;
        end
        if (out_lit !== want.lit) begin
          $display("%0t: lit expected %0d actual %0d", $time, want.lit, out_lit);
          error_count++;
        end
        if (out_red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, out_blue);
          error_count++;
        end
      end
    end
  end

  // receiver stall: mostly short, now and then a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: out_stall <= 1'b0;
        [70:96]: out_stall <= 1'b1;
        default: begin
          stall_left <= $urandom_range(10, 60);
          out_stall <= 1'b1;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers

  function automatic int pick_gap();
    int r;
    if (quiet_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one word, predict it on acceptance, then maybe idle
  task automatic send_word(logic [1:0] cmd, logic [4:0] row, logic [5:0] column);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_row <= row;
    in_column <= column;
    do @(posedge clk); while (in_stall);
    apply_word(cmd, row, column);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic park_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_reads();
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // ticks and fills give no word back, so allow a full fill to finish
  task automatic settle_block();
    wait_for_reads();
    repeat (FILL_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= SEED_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seed_value = value;
    seeds_used++;
    // read it back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $display("%0t: seed readback expected %08h actual %08h", $time, value, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read aimed at or behind a head, falling back to any cell
  task automatic read_near_head();
    int c;
    int r;
    c = $urandom_range(0, COLS - 1);
    r = head_at[c] - int'($urandom_range(0, TAIL));
    if (r < 0 || r >= ROWS) r = $urandom_range(0, ROWS - 1);
    send_word(CMD_READ, 5'(r), 6'(c));
  endtask

  // ---------------------------------------------------------------
  // tests

  // reset fill with the reset seed; corner cells and the unused code
  task automatic test_reset_state();
    send_word(CMD_READ, 5'd0, 6'd0);
    send_word(CMD_READ, 5'(ROWS - 1), 6'(COLS - 1));
    send_word(CMD_READ, 5'd0, 6'(COLS - 1));
    send_word(CMD_READ, 5'(ROWS - 1), 6'd0);
    send_word(CMD_NONE, 5'h1f, 6'h3f);
    send_word(CMD_NONE, 5'd0, 6'd0);
    park_input();
  endtask

  // a few ticks, then reads where the heads are
  task automatic test_ticks();
    repeat (3) send_word(CMD_TICK, 5'h1f, 6'h3f);
    repeat (2) read_near_head();
    park_input();
  endtask

  // zero seed (generator fixup) and all-ones seed
  task automatic test_seed_extremes();
    settle_block();
    write_seed(32'h0000_0000);
    send_word(CMD_INIT, 5'd0, 6'd0);
    send_word(CMD_READ, 5'd0, 6'd0);
    send_word(CMD_READ, 5'(ROWS - 1), 6'(COLS - 1));
    park_input();
    settle_block();
    write_seed(32'hffff_ffff);
    send_word(CMD_INIT, 5'd0, 6'd0);
    send_word(CMD_READ, 5'd0, 6'd0);
    send_word(CMD_READ, 5'(ROWS - 1), 6'(COLS - 1));
    park_input();
  endtask

  // mixed traffic over several seeds and idling styles
  task automatic test_random_traffic();
    int r;
    logic [31:0] s;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_block();
      case (ph)
        0: s = 32'h0000_0001;
        default: s = $urandom;
      endcase
      write_seed(s);
      quiet_in = (ph == 0);
      quiet_out = (ph == 0);
      send_word(CMD_INIT, 5'($urandom), 6'($urandom));
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        r = $urandom_range(0, 199);
        if (r < 80) read_near_head();
        else if (r < 150) send_word(CMD_READ, 5'($urandom), 6'($urandom));
        else if (r < 188) send_word(CMD_TICK, 5'($urandom), 6'($urandom));
        else if (r == 188) send_word(CMD_INIT, 5'($urandom), 6'($urandom));
        else send_word(CMD_NONE, 5'($urandom), 6'($urandom));
        // hold off once until the reads in flight are back
        if (ph == 2 && n == WORDS_PER_PHASE / 2) begin
          park_input();
          wait_for_reads();
        end
      end
      park_input();
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    seed_value = SEED_RESET;
    reseed_rain();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_ticks();
    test_seed_extremes();
    test_random_traffic();

    wait_for_reads();
    repeat (FILL_CYCLES) @(posedge clk);

    $display("covered %0d reads (%0d lit, %0d heads), %0d ticks, %0d reinits, %0d ignored",
             reads_checked, lit_seen, heads_seen, ticks_sent, reinits_sent, ignored_sent);
    $display("seed register written with %0d values, zero and all-ones among them",
             seeds_used);
    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
